@@ rtl/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int unsigned CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    localparam logic signed [31:0] MISS_VALUE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] req_key;
        logic signed [31:0] req_value;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_rd;
    } t_stat;

endpackage

@@ rtl/lkvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: latch request, scan all slots, apply the update.
// ----------------------------------------------------------------------------
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.last_rd) n_state = S_DRAIN;
            end
            // last compare lands here
            S_DRAIN:  n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load   = (r_state == S_IDLE) && start;
    assign o_cmd.rd_en  = (r_state == S_SCAN);
    assign o_cmd.commit = (r_state == S_COMMIT);
    assign busy         = (r_state != S_IDLE);

endmodule

@@ rtl/lkvc_dp.sv @@
// ----------------------------------------------------------------------------
// lkvc_dp
// Key/data memories, valid bits, recency ranks, scan trackers and response.
// ----------------------------------------------------------------------------
module lkvc_dp
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    output t_stat            o_stat,
    output logic             o_rsp_strobe,
    output t_rsp             o_rsp
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int FW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (FW > CAP_W) ? FW : CAP_W;

    logic [31:0] key_mem  [MAX_ENTRIES];
    logic [31:0] data_mem [MAX_ENTRIES];

    t_req             r_req;
    logic [IW-1:0]    r_rd_idx;
    logic             r_cmp_vld;
    logic [IW-1:0]    r_cmp_idx;
    logic [31:0]      r_key_q;
    logic [31:0]      r_data_q;

    logic [MAX_ENTRIES-1:0] r_valid;
    logic [IW-1:0]          r_rec [MAX_ENTRIES];
    logic [FW-1:0]          r_fill;
    logic [CAP_W-1:0]       r_cap;

    logic          r_found;
    logic [IW-1:0] r_found_idx;
    logic [IW-1:0] r_found_rec;
    logic [31:0]   r_found_data;
    logic          r_old_any;
    logic [IW-1:0] r_old_idx;
    logic [IW-1:0] r_old_rec;
    logic          r_free_any;
    logic [IW-1:0] r_free_idx;

    logic r_out_vld;
    t_rsp r_rsp;
    t_rsp n_rsp;

    logic          cmp_v;
    logic [IW-1:0] cmp_rec;
    logic          full;
    logic          do_touch;
    logic [IW-1:0] t_slot;
    logic [FW-1:0] t_limit;
    logic          mem_we;
    logic          ins;

    assign o_stat.last_rd = (r_rd_idx == IW'(MAX_ENTRIES - 1));

    assign cmp_v   = r_valid[r_cmp_idx];
    assign cmp_rec = r_rec[r_cmp_idx];

    // effective capacity is the register clamped to 1..MAX_ENTRIES
    assign full = (r_cap == '0) ? (r_fill != '0)
                : ((CW'(r_fill) >= CW'(r_cap)) || (r_fill >= FW'(MAX_ENTRIES)));

    always_comb begin
        do_touch = 1'b0;
        t_slot   = r_found_idx;
        t_limit  = FW'(r_found_rec);
        mem_we   = 1'b0;
        ins      = 1'b0;
        n_rsp.hit        = r_found;
        n_rsp.read_value = r_req.req_value;
        if (r_req.req_type == REQ_GET) begin
            n_rsp.read_value = r_found ? $signed(r_found_data) : MISS_VALUE;
            do_touch         = r_found;
        end else if (r_found) begin
            mem_we   = 1'b1;
            do_touch = 1'b1;
        end else if (full) begin
            mem_we   = 1'b1;
            do_touch = 1'b1;
            t_slot   = r_old_idx;
            t_limit  = FW'(r_old_rec);
        end else if (r_free_any) begin
            mem_we   = 1'b1;
            do_touch = 1'b1;
            ins      = 1'b1;
            t_slot   = r_free_idx;
            t_limit  = r_fill;
        end
    end

    // memories: one read per scan step, at most one write at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && mem_we) begin
            key_mem[t_slot]  <= r_req.req_key;
            data_mem[t_slot] <= r_req.req_value;
        end
        if (i_cmd.rd_en) begin
            r_key_q  <= key_mem[r_rd_idx];
            r_data_q <= data_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_cmp_idx  <= '0;
            r_valid    <= '0;
            r_fill     <= '0;
            r_cap      <= CAP_RESET;
            r_found    <= 1'b0;
            r_old_any  <= 1'b0;
            r_free_any <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rec[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;

            r_cmp_vld <= i_cmd.rd_en;
            r_cmp_idx <= r_rd_idx;
            r_out_vld <= i_cmd.commit;

            if (i_cmd.load) begin
                r_req      <= i_req;
                r_rd_idx   <= '0;
                r_found    <= 1'b0;
                r_old_any  <= 1'b0;
                r_free_any <= 1'b0;
            end else if (i_cmd.rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end

            if (r_cmp_vld) begin
                if (cmp_v && (r_key_q == r_req.req_key) && !r_found) begin
                    r_found      <= 1'b1;
                    r_found_idx  <= r_cmp_idx;
                    r_found_rec  <= cmp_rec;
                    r_found_data <= r_data_q;
                end
                if (cmp_v && (!r_old_any || (cmp_rec > r_old_rec))) begin
                    r_old_any <= 1'b1;
                    r_old_idx <= r_cmp_idx;
                    r_old_rec <= cmp_rec;
                end
                if (!cmp_v && !r_free_any) begin
                    r_free_any <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end

            if (i_cmd.commit) begin
                r_rsp <= n_rsp;
                if (ins) begin
                    r_valid[t_slot] <= 1'b1;
                    r_fill          <= r_fill + 1'b1;
                end
                if (do_touch) begin
                    // touched slot becomes rank 0; younger entries age by one
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (IW'(i) == t_slot) begin
                            r_rec[i] <= '0;
                        end else if (r_valid[i] && (FW'(r_rec[i]) < t_limit)) begin
                            r_rec[i] <= r_rec[i] + 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_rsp_strobe = r_out_vld;
    assign o_rsp        = r_rsp;

endmodule

@@ rtl/lru_key_value_cache_top.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The block then reads
// its key memory one slot per cycle, so each item holds busy through
// MAX_ENTRIES scan reads, the last compare and the update. The result
// is shown with o_rsp_strobe for exactly one cycle, the first cycle in
// which busy is low again, and cannot be held off; a new item may be
// started in that same cycle. The capacity register is written through
// i_cfg_valid/o_cfg_ready, which is always ready; write it only while the
// block is idle.
module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_rsp_strobe,
    output t_rsp             o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    lkvc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_stat       (stat),
        .o_rsp_strobe (o_rsp_strobe),
        .o_rsp        (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_strobe |=> !o_rsp_strobe)
        else $error("result strobe held for more than one cycle");

    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_strobe |-> ($past(busy) && !busy))
        else $error("result strobe not aligned with end of busy");
`endif

endmodule

@@ verif/lru_key_value_cache_top_tb.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_tb
// Self-checking bench for the LRU key/value cache. A directed table covers
// misses after reset, key and value extremes, updates in place, capacity zero
// evicting its only entry, saturated capacity and eviction below the fill.
// Random phases follow, each with its own capacity, key pool and sender idling.
// Each result is checked against its typed row, else a cycle-free LRU predictor.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_tb
    import lkvc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;

    typedef enum {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_req             req;
        logic             check_typed;
        t_rsp             typed;
        logic [CAP_W-1:0] cap;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_req             i_req = '0;
    logic             o_rsp_strobe;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data = '0;

    lru_key_value_cache_top #(.MAX_ENTRIES(SLOTS)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_rsp_strobe (o_rsp_strobe),
        .o_rsp        (o_rsp),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted cache contents
    logic [31:0]      cached_key   [SLOTS];
    logic [31:0]      cached_data  [SLOTS];
    bit               cached_valid [SLOTS];
    int unsigned      cached_rank  [SLOTS];
    int unsigned      cached_fill = 0;
    logic [CAP_W-1:0] cap_setting = CAP_RESET;

    t_rsp expected_rsp [$];
    t_row directed_rows [$];
    t_rsp want;
    int   items_sent = 0;
    int   results_seen = 0;
    int   hits_seen = 0;
    int   cfg_writes = 0;
    int   mismatches = 0;

    // Entry s becomes most recent; everything younger than lim ages by one.
    function automatic void promote(int s, int unsigned lim);
        for (int i = 0; i < SLOTS; i++) begin
            if (cached_valid[i] && i != s && cached_rank[i] < lim)
                cached_rank[i]++;
        end
        cached_rank[s] = 0;
    endfunction

    function automatic t_rsp cache_access(t_req r);
        int          hit_at;
        int          victim;
        int unsigned oldest;
        int unsigned cap;
        t_rsp        rsp;
        hit_at = -1;
        victim = -1;
        oldest = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit_at < 0 && cached_valid[i] && cached_key[i] == r.req_key)
                hit_at = i;
        end
        if (r.req_type == REQ_GET) begin
            if (hit_at >= 0) begin
                promote(hit_at, cached_rank[hit_at]);
                rsp.hit = 1'b1;
                rsp.read_value = cached_data[hit_at];
            end else begin
                rsp.hit = 1'b0;
                rsp.read_value = MISS_VALUE;
            end
            return rsp;
        end
        rsp.read_value = r.req_value;
        if (hit_at >= 0) begin
            cached_data[hit_at] = r.req_value;
            promote(hit_at, cached_rank[hit_at]);
            rsp.hit = 1'b1;
            return rsp;
        end
        rsp.hit = 1'b0;
        cap = 32'(cap_setting);
        if (cap < 1) cap = 1;
        if (cap > SLOTS) cap = SLOTS;
        if (cached_fill >= cap) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (cached_valid[i] && (victim < 0 || cached_rank[i] > oldest)) begin
                    victim = i;
                    oldest = cached_rank[i];
                end
            end
        end
        if (victim < 0) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (victim < 0 && !cached_valid[i])
                    victim = i;
            end
            if (victim < 0)
                return rsp;
            cached_valid[victim] = 1'b1;
            cached_rank[victim] = cached_fill;
            cached_fill++;
        end
        cached_key[victim] = r.req_key;
        cached_data[victim] = r.req_value;
        promote(victim, cached_rank[victim]);
        return rsp;
    endfunction

    function automatic t_row row_req(logic op, logic [31:0] k, logic [31:0] v);
        t_row row;
        row.kind = ROW_REQ;
        row.req = '{req_type: op, req_key: k, req_value: v};
        row.check_typed = 1'b0;
        row.typed = '0;
        row.cap = '0;
        return row;
    endfunction

    function automatic t_row row_typed(logic op, logic [31:0] k, logic [31:0] v,
                                       logic h, logic [31:0] rv);
        t_row row;
        row = row_req(op, k, v);
        row.check_typed = 1'b1;
        row.typed = '{hit: h, read_value: rv};
        return row;
    endfunction

    function automatic t_row row_cfg(logic [CAP_W-1:0] c);
        t_row row;
        row = row_req(REQ_GET, '0, '0);
        row.kind = ROW_CFG;
        row.cap = c;
        return row;
    endfunction

    // Holds start high until the item is taken; leaves start high afterwards.
    task automatic issue(t_req r, logic use_typed, t_rsp typed);
        t_rsp pred;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        pred = cache_access(r);
        expected_rsp.push_back(use_typed ? typed : pred);
        items_sent++;
    endtask

    task automatic pause_sender(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_setting = c;
        cfg_writes++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_strobe) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result hit=%0b value=%h at %0t",
                             o_rsp.hit, o_rsp.read_value, $realtime);
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.hit !== want.hit || o_rsp.read_value !== want.read_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d: expected hit=%0b value=%h, got hit=%0b value=%h",
                                 results_seen, want.hit, want.read_value,
                                 o_rsp.hit, o_rsp.read_value);
                end
                if (o_rsp.hit === 1'b1)
                    hits_seen++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_rsp.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [CAP_W-1:0] phase_cap [11];
        int               idle_pct [3];
        int               pool_span [3];
        logic [31:0]      key_pool [32];
        t_req             r;
        int               span;
        int               gap_pct;

        phase_cap = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd3, 5'd8, 5'd2,
                      5'd16, 5'd12};
        idle_pct = '{0, 58, 20};
        pool_span = '{6, 20, 32};
        for (int i = 0; i < SLOTS; i++) begin
            cached_valid[i] = 1'b0;
            cached_rank[i] = 0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // misses after reset, then a single-entry cache that must evict its only entry
        directed_rows.push_back(row_typed(REQ_GET, 32'h0000_0000, 32'hDEAD_BEEF, 1'b0, MISS_VALUE));
        directed_rows.push_back(row_typed(REQ_GET, 32'h8000_0000, 32'h0, 1'b0, MISS_VALUE));
        directed_rows.push_back(row_cfg(5'd0));
        directed_rows.push_back(row_typed(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF));
        directed_rows.push_back(row_typed(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h8000_0000));
        directed_rows.push_back(row_typed(REQ_GET, 32'h8000_0000, 32'h0, 1'b0, MISS_VALUE));
        directed_rows.push_back(row_typed(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000));
        directed_rows.push_back(row_typed(REQ_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        // capacity above the store saturates
        directed_rows.push_back(row_cfg(5'd31));
        directed_rows.push_back(row_typed(REQ_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0));
        directed_rows.push_back(row_typed(REQ_PUT, 32'hFFFF_FFFF, 32'h5555_5555, 1'b0, 32'h5555_5555));
        directed_rows.push_back(row_typed(REQ_PUT, 32'h0000_0001, 32'hAAAA_AAAA, 1'b0, 32'hAAAA_AAAA));
        directed_rows.push_back(row_typed(REQ_GET, 32'h0000_0000, 32'h1, 1'b1, 32'h0));
        directed_rows.push_back(row_typed(REQ_GET, 32'h7FFF_FFFF, 32'h2, 1'b1, 32'hFFFF_FFFF));
        directed_rows.push_back(row_typed(REQ_GET, 32'hFFFF_FFFF, 32'h3, 1'b1, 32'h5555_5555));
        // capacity dropped below the fill: misses swap out the oldest
        directed_rows.push_back(row_cfg(5'd2));
        directed_rows.push_back(row_typed(REQ_PUT, 32'h0000_0007, 32'h0000_0007, 1'b0, 32'h7));
        directed_rows.push_back(row_req(REQ_GET, 32'h0000_0001, 32'h0));
        directed_rows.push_back(row_req(REQ_GET, 32'h0000_0000, 32'h0));
        directed_rows.push_back(row_req(REQ_PUT, 32'h0000_0000, 32'h1234_5678));
        directed_rows.push_back(row_cfg(5'd16));
        directed_rows.push_back(row_req(REQ_PUT, 32'h0000_0008, 32'h8765_4321));
        directed_rows.push_back(row_req(REQ_GET, 32'h0000_0007, 32'h0));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_capacity(directed_rows[i].cap);
            else
                issue(directed_rows[i].req, directed_rows[i].check_typed, directed_rows[i].typed);
        end

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 32; i++)
            key_pool[i] = $urandom;

        for (int p = 0; p < 11; p++) begin
            write_capacity(phase_cap[p]);
            gap_pct = idle_pct[p % 3];
            span = pool_span[(p / 3) % 3];
            for (int n = 0; n < 100; n++) begin
                r.req_type = 1'($urandom_range(1));
                r.req_key = ($urandom_range(9) == 0) ? $urandom
                                                     : key_pool[5'($urandom_range(span - 1))];
                r.req_value = $urandom;
                issue(r, 1'b0, '0);
                // once, midway through the fifth phase, let the sender wait for the pipe to empty
                if (p == 4 && n == 50)
                    drain();
                else if ($urandom_range(99) < gap_pct)
                    pause_sender($urandom_range(1, 24));
            end
        end

        start <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);

        $display("Ran %0d requests (%0d results, %0d hits) over %0d capacity settings,",
                 items_sent, results_seen, hits_seen, cfg_writes);
        $display("including capacity 0, 1, 31 and shrink below fill; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_dp.sv
rtl/lru_key_value_cache_top.sv
verif/lru_key_value_cache_top_tb.sv
